@@ rtl/q2rm_pkg.sv @@
// q2rm_pkg: shared types and constants for the quaternion to rotation matrix block
// no dependencies

package q2rm_pkg;

  // default number of fraction bits on the input and output fields
  localparam int FRAC_BITS_DEF = 14;

  // field and intermediate widths
  localparam int DATA_W  = 16;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int NORM_W  = PROD_W + 1;
  localparam int NUM_W   = PROD_W + 2;
  localparam int ENTRIES = 9;

  // matrix entry positions, row major
  localparam int E00 = 0;
  localparam int E01 = 1;
  localparam int E02 = 2;
  localparam int E10 = 3;
  localparam int E11 = 4;
  localparam int E12 = 5;
  localparam int E20 = 6;
  localparam int E21 = 7;
  localparam int E22 = 8;

  // entries on the diagonal, set to one for a zero quaternion
  localparam logic [ENTRIES-1:0] DIAG_MASK = 9'b100010001;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic        [NORM_W-1:0] norm_t;
  typedef logic signed [NUM_W-1:0]  num_t;

endpackage

@@ rtl/quaternion_to_rotation_matrix.sv @@
// quaternion to 3x3 rotation matrix, numerators divided by the squared norm, rounded and saturated
// stages: products, sums, magnitude, one restoring division step per stage for
// FRAC_BITS+2 stages, then rounding
// throughput: one transaction per cycle while mat_stall is low; stages collapse bubbles under stall
// reset: synchronous, clears the stage valid bits only
// depends on q2rm_pkg

module quaternion_to_rotation_matrix
  import q2rm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  quat_valid,
  output logic  quat_stall,
  input  data_t q_w,
  input  data_t q_x,
  input  data_t q_y,
  input  data_t q_z,
  output logic  mat_valid,
  input  logic  mat_stall,
  output data_t m00,
  output data_t m01,
  output data_t m02,
  output data_t m10,
  output data_t m11,
  output data_t m12,
  output data_t m20,
  output data_t m21,
  output data_t m22,
  output logic  zero_norm
);

  localparam int DIV_STEPS = FRAC_BITS + 2;
  localparam int QW        = FRAC_BITS + 2;
  localparam int NST       = DIV_STEPS + 4;
  localparam int ST_PROD   = 0;
  localparam int ST_SUM    = 1;
  localparam int ST_MAG    = 2;
  localparam int ST_DIV0   = 3;
  localparam int ST_OUT    = NST - 1;
  localparam int CMP_W     = (FRAC_BITS + 1 > DATA_W + 1) ? FRAC_BITS + 1 : DATA_W + 1;
  localparam logic [CMP_W-1:0] POS_LIM = CMP_W'(2 ** (DATA_W - 1) - 1);
  localparam logic [CMP_W-1:0] NEG_LIM = CMP_W'(2 ** (DATA_W - 1));
  localparam data_t DATA_MAX = data_t'(2 ** (DATA_W - 1) - 1);
  localparam data_t DATA_MIN = data_t'(-(2 ** (DATA_W - 1)));
  localparam data_t ONE_VAL  = data_t'((FRAC_BITS >= DATA_W - 1) ?
                                       2 ** (DATA_W - 1) - 1 : 2 ** FRAC_BITS);

  // stage valid bits and per-stage advance
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end
  assign en[NST-1] = ~v[NST-1] | ~mat_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~en) | ({v[NST-2:0], quat_valid} & en);
    end
  end

  assign quat_stall = ~en[ST_PROD];
  assign mat_valid  = v[ST_OUT];

  // products of the quaternion parts
  prod_t p_ww, p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_xw, p_yw, p_zw;

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      p_ww <= prod_t'(q_w) * prod_t'(q_w);
      p_xx <= prod_t'(q_x) * prod_t'(q_x);
      p_yy <= prod_t'(q_y) * prod_t'(q_y);
      p_zz <= prod_t'(q_z) * prod_t'(q_z);
      p_xy <= prod_t'(q_x) * prod_t'(q_y);
      p_xz <= prod_t'(q_x) * prod_t'(q_z);
      p_yz <= prod_t'(q_y) * prod_t'(q_z);
      p_xw <= prod_t'(q_x) * prod_t'(q_w);
      p_yw <= prod_t'(q_y) * prod_t'(q_w);
      p_zw <= prod_t'(q_z) * prod_t'(q_w);
    end
  end

  // squared norm and the nine numerators
  norm_t nrm1;
  num_t  num1 [ENTRIES];

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      nrm1      <= norm_t'(p_ww) + norm_t'(p_xx) + norm_t'(p_yy) + norm_t'(p_zz);
      num1[E00] <= num_t'(p_ww) + num_t'(p_xx) - num_t'(p_yy) - num_t'(p_zz);
      num1[E11] <= num_t'(p_ww) - num_t'(p_xx) + num_t'(p_yy) - num_t'(p_zz);
      num1[E22] <= num_t'(p_ww) - num_t'(p_xx) - num_t'(p_yy) + num_t'(p_zz);
      num1[E01] <= (num_t'(p_xy) + num_t'(p_zw)) <<< 1;
      num1[E10] <= (num_t'(p_xy) - num_t'(p_zw)) <<< 1;
      num1[E02] <= (num_t'(p_xz) - num_t'(p_yw)) <<< 1;
      num1[E20] <= (num_t'(p_xz) + num_t'(p_yw)) <<< 1;
      num1[E12] <= (num_t'(p_yz) + num_t'(p_xw)) <<< 1;
      num1[E21] <= (num_t'(p_yz) - num_t'(p_xw)) <<< 1;
    end
  end

  // magnitude and sign; a numerator never exceeds the norm in magnitude
  norm_t              nrm2;
  norm_t              mag2 [ENTRIES];
  logic [ENTRIES-1:0] neg2;
  logic               zero2;

  always_ff @(posedge clk) begin
    if (en[ST_MAG]) begin
      nrm2  <= nrm1;
      zero2 <= (nrm1 == '0);
      for (int e = 0; e < ENTRIES; e++) begin
        neg2[e] <= num1[e][NUM_W-1];
        mag2[e] <= norm_t'(num1[e][NUM_W-1] ? -num1[e] : num1[e]);
      end
    end
  end

  // restoring division of mag * 2^(FRAC_BITS+1) by the norm, one bit per stage
  norm_t              rem    [DIV_STEPS][ENTRIES];
  logic [QW-1:0]      qacc   [DIV_STEPS][ENTRIES];
  norm_t              nrm_d  [DIV_STEPS];
  logic [ENTRIES-1:0] neg_d  [DIV_STEPS];
  logic [DIV_STEPS-1:0] zero_d;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [NORM_W:0]    trial  [ENTRIES];
    logic [NORM_W:0]    diff   [ENTRIES];
    logic [QW-1:0]      q_prev [ENTRIES];
    logic [ENTRIES-1:0] qbit;
    norm_t              n_prev;
    logic [ENTRIES-1:0] neg_prev;
    logic               zero_prev;

    if (j == 0) begin : g_first
      // integer bit: magnitude against the norm
      always_comb begin
        for (int e = 0; e < ENTRIES; e++) begin
          trial[e]  = {1'b0, mag2[e]};
          q_prev[e] = '0;
        end
      end
      assign n_prev    = nrm2;
      assign neg_prev  = neg2;
      assign zero_prev = zero2;
    end else begin : g_rest
      // fraction bits: doubled remainder against the norm
      always_comb begin
        for (int e = 0; e < ENTRIES; e++) begin
          trial[e]  = {rem[j-1][e], 1'b0};
          q_prev[e] = qacc[j-1][e];
        end
      end
      assign n_prev    = nrm_d[j-1];
      assign neg_prev  = neg_d[j-1];
      assign zero_prev = zero_d[j-1];
    end

    // trial subtract, borrow decides the quotient bit
    always_comb begin
      for (int e = 0; e < ENTRIES; e++) begin
        diff[e] = trial[e] - {1'b0, n_prev};
        qbit[e] = ~diff[e][NORM_W];
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_DIV0+j]) begin
        nrm_d[j]  <= n_prev;
        neg_d[j]  <= neg_prev;
        zero_d[j] <= zero_prev;
        for (int e = 0; e < ENTRIES; e++) begin
          rem[j][e]  <= qbit[e] ? diff[e][NORM_W-1:0] : trial[e][NORM_W-1:0];
          qacc[j][e] <= {q_prev[e][QW-2:0], qbit[e]};
        end
      end
    end
  end

  // round half away from zero, apply sign, clamp to the field range; a zero norm sets the diagonal to one
  logic [QW-1:0]    rnd    [ENTRIES];
  logic [CMP_W-1:0] qmag   [ENTRIES];
  data_t            m_next [ENTRIES];
  data_t            mout   [ENTRIES];
  logic             zero_out;

  always_comb begin
    for (int e = 0; e < ENTRIES; e++) begin
      rnd[e]  = qacc[DIV_STEPS-1][e] + QW'(1);
      qmag[e] = CMP_W'(rnd[e][QW-1:1]);
      if (zero_d[DIV_STEPS-1]) begin
        m_next[e] = DIAG_MASK[e] ? ONE_VAL : '0;
      end else if (neg_d[DIV_STEPS-1][e]) begin
        m_next[e] = (qmag[e] > NEG_LIM) ? DATA_MIN : -data_t'(qmag[e]);
      end else begin
        m_next[e] = (qmag[e] > POS_LIM) ? DATA_MAX : data_t'(qmag[e]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      mout     <= m_next;
      zero_out <= zero_d[DIV_STEPS-1];
    end
  end

  assign m00       = mout[E00];
  assign m01       = mout[E01];
  assign m02       = mout[E02];
  assign m10       = mout[E10];
  assign m11       = mout[E11];
  assign m12       = mout[E12];
  assign m20       = mout[E20];
  assign m21       = mout[E21];
  assign m22       = mout[E22];
  assign zero_norm = zero_out;

endmodule
